// ===== rtl/rlcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlcmc_pkg
// Shared types, constants and saturating helpers for the run-length
// constrained min-cost block.
// ----------------------------------------------------------------------------
package rlcmc_pkg;

	localparam int COST_W = 11;
	localparam int REG_W  = 7;
	localparam int RES_W  = 32;

	typedef logic [RES_W-1:0]  cost_t;
	typedef logic [COST_W-1:0] col_cost_t;
	typedef logic [REG_W-1:0]  run_len_t;

	typedef logic [1:0][RES_W-1:0]  cost_pair_t;
	typedef logic [1:0][COST_W-1:0] col_pair_t;

	// all ones stands for an unreachable state
	localparam cost_t COST_INF = '1;

	typedef enum logic [0:0] {
		REG_MIN_RUN = 1'b0,
		REG_MAX_RUN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic acc;
		logic first;
	} cell_ctl_t;

	typedef struct packed {
		logic adv;
		logic acc;
	} tree_ctl_t;

	function automatic cost_t sat_add(cost_t a, cost_t b);
		logic [RES_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, COST_INF}) ? COST_INF : s[RES_W-1:0];
	endfunction

	function automatic cost_t min2(cost_t a, cost_t b);
		return (b < a) ? b : a;
	endfunction

endpackage

// ===== rtl/rlcmc_if.sv =====
// ----------------------------------------------------------------------------
// rlcmc channel interfaces
// Column input, result output and register write channels, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface rlcmc_col_if;
	logic                  valid;
	logic                  ready;
	rlcmc_pkg::col_cost_t  cost_colour_zero;
	rlcmc_pkg::col_cost_t  cost_colour_one;
	logic                  first_column;
	logic                  last_column;

	modport source (
		output valid, cost_colour_zero, cost_colour_one, first_column, last_column,
		input  ready
	);
	modport sink (
		input  valid, cost_colour_zero, cost_colour_one, first_column, last_column,
		output ready
	);
endinterface

interface rlcmc_res_if;
	logic                  valid;
	logic                  ready;
	rlcmc_pkg::cost_t      min_total_cost;
	logic                  feasible;

	modport source (
		output valid, min_total_cost, feasible,
		input  ready
	);
	modport sink (
		input  valid, min_total_cost, feasible,
		output ready
	);
endinterface

interface rlcmc_cfg_if;
	logic                  valid;
	logic                  ready;
	logic [0:0]            idx;
	rlcmc_pkg::run_len_t   data;

	modport source (
		output valid, idx, data,
		input  ready
	);
	modport sink (
		input  valid, idx, data,
		output ready
	);
endinterface

// ===== rtl/rlcmc_cell.sv =====
// ----------------------------------------------------------------------------
// rlcmc_cell
// One run-length entry of the cost table, both colours. Takes the entry of
// the next shorter run from its neighbor and adds this column's cost.
// ----------------------------------------------------------------------------
module rlcmc_cell #(
	parameter int IDX = 1
) (
	input  logic                   clk,
	input  rlcmc_pkg::cell_ctl_t   ctl,
	input  rlcmc_pkg::col_pair_t   cost,
	input  rlcmc_pkg::run_len_t    hi,
	input  rlcmc_pkg::cost_pair_t  din,
	output rlcmc_pkg::cost_pair_t  q
);

	localparam bit FITS = IDX < (1 << rlcmc_pkg::REG_W);

	rlcmc_pkg::cost_pair_t val_q;
	rlcmc_pkg::cost_pair_t nxt;
	logic                  in_range;

	assign in_range = FITS && (hi >= rlcmc_pkg::run_len_t'(IDX));

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			if (ctl.first) begin
				nxt[c] = (IDX == 1) ? rlcmc_pkg::cost_t'(cost[c]) : rlcmc_pkg::COST_INF;
			end else if (in_range) begin
				nxt[c] = rlcmc_pkg::sat_add(din[c], rlcmc_pkg::cost_t'(cost[c]));
			end else begin
				nxt[c] = rlcmc_pkg::COST_INF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			val_q <= nxt;
		end
	end

	assign q = val_q;

endmodule

// ===== rtl/rlcmc_min_tree.sv =====
// ----------------------------------------------------------------------------
// rlcmc_min_tree
// Pipelined minimum over a masked window of the cost table. Advances one
// level per step; the column costs added meanwhile ride along as a sum.
// ----------------------------------------------------------------------------
module rlcmc_min_tree #(
	parameter int N   = 64,
	parameter int LVL = 6,
	parameter int MW  = 3,
	parameter int CW  = 14
) (
	input  logic                                  clk,
	input  rlcmc_pkg::tree_ctl_t                  ctl,
	input  logic [1:0][N-1:0][rlcmc_pkg::RES_W-1:0] tab,
	input  rlcmc_pkg::run_len_t                   lo,
	input  rlcmc_pkg::run_len_t                   hi,
	input  logic [MW-1:0]                         m,
	input  rlcmc_pkg::col_pair_t                  cost,
	output rlcmc_pkg::cost_pair_t                 root,
	output logic [1:0][CW-1:0]                    csum
);

	localparam int N2    = 1 << LVL;
	localparam int NODES = 2 * N2 - 1;
	localparam int LW    = $clog2(N + 1);
	localparam int IW    = ((LW > rlcmc_pkg::REG_W) ? LW : rlcmc_pkg::REG_W) + 2;

	rlcmc_pkg::cost_t node_q [2][NODES];
	logic [CW-1:0]    csum_q [LVL+1][2];
	rlcmc_pkg::cost_t leaf   [2][N2];
	logic [CW-1:0]    add    [2];
	logic [IW-1:0]    lm;

	// leaf j holds run length j+1; it lands at length j+1+m when used
	always_comb begin
		lm = '0;
		for (int c = 0; c < 2; c++) begin
			for (int j = 0; j < N2; j++) begin
				leaf[c][j] = rlcmc_pkg::COST_INF;
			end
			for (int j = 0; j < N; j++) begin
				lm = IW'(j + 1) + IW'(m);
				if ((lm >= IW'(lo)) && ((m == '0) || (lm <= IW'(hi)))) begin
					leaf[c][j] = tab[c][j];
				end
			end
			add[c] = ctl.acc ? CW'(cost[c]) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int c = 0; c < 2; c++) begin
				for (int j = 0; j < N2; j++) begin
					node_q[c][N2-1+j] <= leaf[c][j];
				end
				for (int i = 0; i < N2 - 1; i++) begin
					node_q[c][i] <= rlcmc_pkg::min2(node_q[c][2*i+1], node_q[c][2*i+2]);
				end
				csum_q[0][c] <= add[c];
				for (int s = 1; s <= LVL; s++) begin
					csum_q[s][c] <= csum_q[s-1][c] + add[c];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			root[c] = node_q[c][0];
			csum[c] = csum_q[LVL][c];
		end
	end

endmodule

// ===== rtl/run_length_constrained_min_cost.sv =====
// ----------------------------------------------------------------------------
// run_length_constrained_min_cost
// Forward Viterbi over two colours with run length limits; reports the least
// total cost of a sequence of columns.
// ----------------------------------------------------------------------------
// Usage:
//   columns : one item per column, costs for colour zero and one plus
//             first/last marks. A sequence must open with first_column.
//   results : one item per column marked last: least total cost over runs
//             ending at min_run or longer, and a feasible flag.
//   cfg     : writes min_run (idx 0) and max_run (idx 1); ready is always high.
// Columns are taken one per cycle while columns.ready is high. A last column
// sets pend_q, whose result then moves to the output register, or to the skid
// entry while results stalls. The table is a row of MAX_RUN cells updated in
// parallel; the least cost of long runs comes from a pipelined min tree of
// $clog2(MAX_RUN)+1 levels whose result is corrected by the costs added
// meanwhile, while short runs are read straight from the cells. After each
// register write the tree refills, and columns.ready is low meanwhile.
// When results stalls, a two-entry output buffer absorbs results and the
// column input keeps flowing until both entries are taken.
// Reset restores min_run=1, max_run=64 and empties the output; the table
// itself is not cleared.
// ----------------------------------------------------------------------------
module run_length_constrained_min_cost #(
	parameter int MAX_RUN = 64
) (
	input  logic clk,
	input  logic arst_n,
	rlcmc_col_if.sink   columns,
	rlcmc_res_if.source results,
	rlcmc_cfg_if.sink   cfg
);

	localparam int LVL = $clog2(MAX_RUN);
	localparam int D   = LVL + 1;
	localparam int DR  = (D < MAX_RUN) ? D : MAX_RUN;
	localparam int MW  = $clog2(D + 1);
	localparam int GW  = $clog2(D + 2);
	localparam int CW  = rlcmc_pkg::COST_W + $clog2(D + 1);
	localparam int LW  = $clog2(MAX_RUN + 1);
	localparam int IW  = ((LW > rlcmc_pkg::REG_W) ? LW : rlcmc_pkg::REG_W) + 2;

	rlcmc_pkg::run_len_t   min_run_q;
	rlcmc_pkg::run_len_t   max_run_q;
	rlcmc_pkg::run_len_t   lo;
	rlcmc_pkg::run_len_t   hi;
	logic [MW-1:0]         prime_q;
	logic                  priming;
	logic [MW-1:0]         m;
	logic [GW-1:0]         gap_q;
	logic                  acc;
	rlcmc_pkg::col_pair_t  cost;
	rlcmc_pkg::cell_ctl_t  cell_ctl;
	rlcmc_pkg::tree_ctl_t  tree_ctl;

	rlcmc_pkg::cost_pair_t cell_q [MAX_RUN];
	logic [1:0][MAX_RUN-1:0][rlcmc_pkg::RES_W-1:0] tab;
	rlcmc_pkg::cost_pair_t root;
	logic [1:0][CW-1:0]    csum;
	rlcmc_pkg::cost_pair_t tail;
	rlcmc_pkg::cost_pair_t row0_in;
	rlcmc_pkg::cost_t      near;
	rlcmc_pkg::cost_t      far;
	rlcmc_pkg::cost_t      res;

	logic                  pend_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;
	rlcmc_pkg::cost_t      out_cost_q;
	rlcmc_pkg::cost_t      skid_cost_q;
	logic                  drain;
	logic                  out_free;
	logic [1:0]            occ;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q <= rlcmc_pkg::run_len_t'(1);
			max_run_q <= rlcmc_pkg::run_len_t'(64);
		end else if (cfg.valid) begin
			unique case (rlcmc_pkg::cfg_reg_t'(cfg.idx))
				rlcmc_pkg::REG_MIN_RUN: min_run_q <= cfg.data;
				rlcmc_pkg::REG_MAX_RUN: max_run_q <= cfg.data;
			endcase
		end
	end

	always_comb begin
		lo = (min_run_q == '0) ? rlcmc_pkg::run_len_t'(1) : min_run_q;
		if (max_run_q == '0) begin
			hi = rlcmc_pkg::run_len_t'(1);
		end else if (IW'(max_run_q) > IW'(MAX_RUN)) begin
			hi = rlcmc_pkg::run_len_t'(MAX_RUN);
		end else begin
			hi = max_run_q;
		end
	end

	// tree refill after a register write: launch k serves the k-th next column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= MW'(D);
		end else if (cfg.valid) begin
			prime_q <= '0;
		end else if (priming) begin
			prime_q <= prime_q + MW'(1);
		end
	end

	assign priming = prime_q != MW'(D);
	assign m       = priming ? prime_q : MW'(D);

	// ---------------- column handshake ----------------
	assign drain    = out_valid_q & results.ready;
	assign out_free = ~out_valid_q | drain;
	assign occ      = 2'(out_valid_q) + 2'(skid_valid_q) + 2'(pend_q) - 2'(drain);

	assign columns.ready = ~priming & (occ < 2'd2);
	assign acc           = columns.valid & columns.ready;

	assign cost[0] = columns.cost_colour_zero;
	assign cost[1] = columns.cost_colour_one;

	// columns since the last first mark; tree is usable once past its depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (acc) begin
			if (columns.first_column) begin
				gap_q <= GW'(1);
			end else if (gap_q != GW'(D + 1)) begin
				gap_q <= gap_q + GW'(1);
			end
		end
	end

	assign cell_ctl.acc   = acc;
	assign cell_ctl.first = columns.first_column;
	assign tree_ctl.adv   = acc | priming;
	assign tree_ctl.acc   = acc;

	// ---------------- cell row ----------------
	assign row0_in[0] = tail[1];
	assign row0_in[1] = tail[0];

	for (genvar l = 0; l < MAX_RUN; l++) begin : g_cell
		rlcmc_cell #(
			.IDX (l + 1)
		) u_cell (
			.clk  (clk),
			.ctl  (cell_ctl),
			.cost (cost),
			.hi   (hi),
			.din  ((l == 0) ? row0_in : cell_q[(l == 0) ? 0 : l-1]),
			.q    (cell_q[l])
		);
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			for (int l = 0; l < MAX_RUN; l++) begin
				tab[c][l] = cell_q[l][c];
			end
		end
	end

	rlcmc_min_tree #(
		.N   (MAX_RUN),
		.LVL (LVL),
		.MW  (MW),
		.CW  (CW)
	) u_tree (
		.clk  (clk),
		.ctl  (tree_ctl),
		.tab  (tab),
		.lo   (lo),
		.hi   (hi),
		.m    (m),
		.cost (cost),
		.root (root),
		.csum (csum)
	);

	// least cost of runs at min_run or longer in the current table:
	// short runs straight from the cells, longer ones from the tree
	always_comb begin
		near = rlcmc_pkg::COST_INF;
		far  = rlcmc_pkg::COST_INF;
		for (int c = 0; c < 2; c++) begin
			near = rlcmc_pkg::COST_INF;
			for (int l = 1; l <= DR; l++) begin
				if (IW'(l) >= IW'(lo)) begin
					near = rlcmc_pkg::min2(near, cell_q[l-1][c]);
				end
			end
			far = (gap_q == GW'(D + 1))
				? rlcmc_pkg::sat_add(root[c], rlcmc_pkg::cost_t'(csum[c]))
				: rlcmc_pkg::COST_INF;
			tail[c] = rlcmc_pkg::min2(near, far);
		end
	end

	assign res = rlcmc_pkg::min2(tail[0], tail[1]);

	// ---------------- result buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			pend_q <= acc & columns.last_column;
			if (out_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= pend_q;
				end else begin
					out_valid_q  <= pend_q;
				end
			end else if (pend_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_cost_q <= skid_cost_q;
				if (pend_q) begin
					skid_cost_q <= res;
				end
			end else if (pend_q) begin
				out_cost_q <= res;
			end
		end else if (pend_q) begin
			skid_cost_q <= res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.min_total_cost = out_cost_q;
	assign results.feasible       = out_cost_q != rlcmc_pkg::COST_INF;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for run_length_constrained_min_cost. A forward Viterbi tracker
// follows every accepted column and queues the expected least cost and
// feasible flag for each column marked last. Results are checked in order as
// they leave the block. Directed columns come first, then random sequences
// under many run length settings, with random idling on both sides and a
// long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TB_MAX_RUN    = 64;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;

	typedef rlcmc_pkg::cost_t run_table_t [2][TB_MAX_RUN];

	typedef struct {
		rlcmc_pkg::col_cost_t c0;
		rlcmc_pkg::col_cost_t c1;
		logic                 first_col;
		logic                 last_col;
	} column_t;

	class viterbi_cost_tracker;
		run_table_t          runs;
		rlcmc_pkg::run_len_t min_run;
		rlcmc_pkg::run_len_t max_run;
		rlcmc_pkg::cost_t    pending_totals [$];
		logic                pending_feasible [$];
		int                  errors;

		function new();
			min_run = 7'd1;
			max_run = 7'd64;
			errors  = 0;
		endfunction

		function void set_reg(rlcmc_pkg::cfg_reg_t r, rlcmc_pkg::run_len_t v);
			if (r == rlcmc_pkg::REG_MIN_RUN) begin
				min_run = v;
			end else begin
				max_run = v;
			end
		endfunction

		function rlcmc_pkg::cost_t add_sat(rlcmc_pkg::cost_t a, rlcmc_pkg::col_cost_t b);
			logic [rlcmc_pkg::RES_W:0] s;
			s = {1'b0, a} + (rlcmc_pkg::RES_W + 1)'(b);
			return (s >= {1'b0, rlcmc_pkg::COST_INF}) ? rlcmc_pkg::COST_INF
				: s[rlcmc_pkg::RES_W-1:0];
		endfunction

		// least entry of colour c over run lengths lo and up
		function rlcmc_pkg::cost_t least_run(run_table_t tab, int c, int lo);
			rlcmc_pkg::cost_t best;
			best = rlcmc_pkg::COST_INF;
			for (int l = lo; l <= TB_MAX_RUN; l++) begin
				if (tab[c][l-1] < best) begin
					best = tab[c][l-1];
				end
			end
			return best;
		endfunction

		function void note_column(column_t col);
			run_table_t           prev;
			rlcmc_pkg::col_cost_t cst [2];
			rlcmc_pkg::cost_t     b0, b1;
			int                   lo, hi;
			lo = (min_run == 0) ? 1 : int'(min_run);
			hi = (max_run == 0) ? 1 : ((max_run > TB_MAX_RUN) ? TB_MAX_RUN : int'(max_run));
			prev = runs;
			cst[0] = col.c0;
			cst[1] = col.c1;
			for (int c = 0; c < 2; c++) begin
				if (col.first_col) begin
					runs[c][0] = rlcmc_pkg::cost_t'(cst[c]);
					for (int l = 2; l <= TB_MAX_RUN; l++) begin
						runs[c][l-1] = rlcmc_pkg::COST_INF;
					end
				end else begin
					runs[c][0] = add_sat(least_run(prev, 1 - c, lo), cst[c]);
					for (int l = 2; l <= TB_MAX_RUN; l++) begin
						runs[c][l-1] = (l <= hi) ? add_sat(prev[c][l-2], cst[c])
							: rlcmc_pkg::COST_INF;
					end
				end
			end
			if (col.last_col) begin
				b0 = least_run(runs, 0, lo);
				b1 = least_run(runs, 1, lo);
				pending_totals.push_back((b1 < b0) ? b1 : b0);
				pending_feasible.push_back(((b1 < b0) ? b1 : b0) != rlcmc_pkg::COST_INF);
			end
		endfunction

		function void check_total(rlcmc_pkg::cost_t got_cost, logic got_feas);
			rlcmc_pkg::cost_t want_cost;
			logic             want_feas;
			if (pending_totals.size() == 0) begin
				$display("%0t: unexpected result min_total_cost=%0d feasible=%0b",
					$time, got_cost, got_feas);
				errors++;
				return;
			end
			want_cost = pending_totals.pop_front();
			want_feas = pending_feasible.pop_front();
			if (got_cost !== want_cost) begin
				$display("%0t: min_total_cost expected %0d actual %0d",
					$time, want_cost, got_cost);
				errors++;
			end
			if (got_feas !== want_feas) begin
				$display("%0t: feasible expected %0b actual %0b", $time, want_feas, got_feas);
				errors++;
			end
		endfunction

		function int pending();
			return pending_totals.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rlcmc_col_if col_ch ();
	rlcmc_res_if res_ch ();
	rlcmc_cfg_if cfg_ch ();

	run_length_constrained_min_cost #(.MAX_RUN(TB_MAX_RUN)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.columns (col_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	viterbi_cost_tracker tracker = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_len = 0;
	int cur_min     = 1;
	int stall_cycles = 0;

	int seg_min [10] = '{2, 1, 3, 0, 64, 65, 5, 127, 1, 6};
	int seg_max [10] = '{4, 1, 3, 0, 64, 127, 2, 0, 127, 20};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result sink: random ready, or a long hold when one is requested
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				res_ch.ready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			tracker.check_total(res_ch.min_total_cost, res_ch.feasible);
		end
	end

	always @(posedge clk) begin
		if ((col_ch.valid && col_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("[run_length_constrained_min_cost] ERROR");
			$finish;
		end
	end

	function automatic rlcmc_pkg::col_cost_t random_cost();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return rlcmc_pkg::col_cost_t'(1024);
			default: return rlcmc_pkg::col_cost_t'($urandom_range(2047));
		endcase
	endfunction

	task automatic send_column(input rlcmc_pkg::col_cost_t c0, input rlcmc_pkg::col_cost_t c1,
		input logic first_col, input logic last_col);
		column_t col;
		col.c0 = c0;
		col.c1 = c1;
		col.first_col = first_col;
		col.last_col = last_col;
		while ($urandom_range(99) < tx_idle_pct) begin
			col_ch.valid <= 1'b0;
			@(posedge clk);
		end
		col_ch.valid            <= 1'b1;
		col_ch.cost_colour_zero <= c0;
		col_ch.cost_colour_one  <= c1;
		col_ch.first_column     <= first_col;
		col_ch.last_column      <= last_col;
		do @(posedge clk); while (!col_ch.ready);
		tracker.note_column(col);
	endtask

	task automatic send_sequence(input int len);
		for (int i = 0; i < len; i++) begin
			send_column(random_cost(), random_cost(), i == 0, i == len - 1);
		end
	endtask

	// stop offering columns and let every expected result come out
	task automatic drain();
		col_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input int min_v, input int max_v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.idx   <= rlcmc_pkg::REG_MIN_RUN;
		cfg_ch.data  <= rlcmc_pkg::run_len_t'(min_v);
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.set_reg(rlcmc_pkg::REG_MIN_RUN, rlcmc_pkg::run_len_t'(min_v));
		cfg_ch.idx   <= rlcmc_pkg::REG_MAX_RUN;
		cfg_ch.data  <= rlcmc_pkg::run_len_t'(max_v);
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.set_reg(rlcmc_pkg::REG_MAX_RUN, rlcmc_pkg::run_len_t'(max_v));
		cfg_ch.valid <= 1'b0;
		cur_min = min_v;
	endtask

	// mostly whole sequences; some stray columns with random marks
	task automatic run_random(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(9) == 0) begin
					if ($urandom_range(1) == 1 && cur_min >= 1 && cur_min <= TB_MAX_RUN) begin
						len = cur_min * $urandom_range(1, 2);
					end else begin
						len = $urandom_range(55, 140);
					end
				end else begin
					len = $urandom_range(1, 24);
				end
				send_sequence(len);
				sent += len;
			end else begin
				send_column(random_cost(), random_cost(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n                  = 1'b0;
		col_ch.valid            = 1'b0;
		col_ch.cost_colour_zero = '0;
		col_ch.cost_colour_one  = '0;
		col_ch.first_column     = 1'b0;
		col_ch.last_column      = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.idx              = rlcmc_pkg::REG_MIN_RUN;
		cfg_ch.data             = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 21;
		rx_idle_pct = 56;

		// one-column sequences at the cost extremes, then a four-column one
		send_column(11'd0, 11'd2047, 1'b1, 1'b1);
		send_column(11'd2047, 11'd0, 1'b1, 1'b1);
		send_column(11'd1024, 11'd1024, 1'b1, 1'b1);
		send_column(11'd2047, 11'd2047, 1'b1, 1'b0);
		send_column(11'd0, 11'd0, 1'b0, 1'b0);
		send_column(11'd1024, 11'd1, 1'b0, 1'b0);
		send_column(11'd2, 11'd1023, 1'b0, 1'b1);
		// sequence dropped by a new first column
		send_column(11'd5, 11'd7, 1'b1, 1'b0);
		send_column(11'd3, 11'd3, 1'b0, 1'b0);
		send_column(11'd9, 11'd4, 1'b1, 1'b0);
		send_column(11'd6, 11'd8, 1'b0, 1'b1);
		// keeps going past a last column
		send_column(11'd1, 11'd1, 1'b0, 1'b1);

		write_regs(3, 4);
		// shorter than min_run: infeasible
		send_column(11'd100, 11'd0, 1'b1, 1'b1);
		// alternating cheap colour fights the run limits
		for (int i = 0; i < 9; i++) begin
			send_column(i[0] ? 11'd0 : 11'd500, i[0] ? 11'd500 : 11'd0, i == 0, i == 8);
		end

		for (int seg = 0; seg < 10; seg++) begin
			if (seg == 4) begin
				tx_idle_pct = 56;
				rx_idle_pct = 21;
			end
			if (seg == 7) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				drain();
				// output held off while single-column sequences pile up
				rx_hold_len = HOLD_CYCLES;
				for (int k = 0; k < 40; k++) begin
					send_column(random_cost(), random_cost(), 1'b1, 1'b1);
				end
				drain();
			end
			write_regs(seg_min[seg], seg_max[seg]);
			run_random(110);
		end

		col_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("[run_length_constrained_min_cost] OK");
		end else begin
			$display("[run_length_constrained_min_cost] ERROR");
		end
		$finish;
	end

endmodule
